### design/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Types and codes shared by the sorted list engine and its cells.
// ----------------------------------------------------------------------------
package sle_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_READ   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STS_DONE   = 2'd0,
    STS_ABSENT = 2'd1,
    STS_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXE
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [3:0]         index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         position;
    logic [4:0]         entry_count;
    logic signed [31:0] read_value;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic load;
    logic cmp;
    logic exe;
  } ctrl_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage
`default_nettype wire

### design/sorted_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_engine
// Ascending list of signed words held in a chain of cells.
// The result strobe rises after the compare and execute states that follow the load.
// One word at a time (load, cell compare, shift/execute); start is taken only in idle.
// busy is high for the compare and execute cycles; results cannot be stalled.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_engine import sle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_word_t  in_word,
  output logic           busy,
  output logic           out_valid,
  output out_word_t      out_word
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int RD_N = (DEPTH < 16) ? DEPTH : 16;

  ctrl_t     ctrl;
  state_e    state_r;
  in_word_t  cmd_r;
  cell_ctl_t cell_ctl;

  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r;
  out_word_t          out_word_r, out_word_nxt;

  logic signed [31:0] cval [DEPTH];
  logic               cgt  [DEPTH];
  logic               ceq  [DEPTH];
  logic               csel [DEPTH];

  logic               match;
  logic [3:0]         match_pos;
  logic               read_hit;
  logic signed [31:0] read_data;
  logic               full;

  sle_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .ctrl    (ctrl),
    .state_r (state_r)
  );

  assign busy = ctrl.busy;
  assign full = count_r >= CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_word;
    end
  end

  always_comb begin
    match     = 1'b0;
    match_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match = match | ceq[i];
      if (ceq[i] && (i == 0 || !ceq[(i == 0) ? 0 : i - 1])) begin
        match_pos = match_pos | 4'(i);
      end
    end
  end

  always_comb begin
    read_hit  = 1'b0;
    read_data = '0;
    for (int i = 0; i < RD_N; i++) begin
      read_hit  = read_hit | csel[i];
      read_data = read_data | (cval[i] & {32{csel[i]}});
    end
  end

  always_comb begin
    cell_ctl.cmp = ctrl.cmp;
    cell_ctl.ins = ctrl.exe && (cmd_r.action == ACT_INSERT) && !full;
    cell_ctl.del = ctrl.exe && (cmd_r.action == ACT_DELETE) && match;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sle_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .cmd_value (cmd_r.value),
      .cmd_index (cmd_r.index),
      .count     (count_r),
      .left_val  ((g == 0) ? 32'sd0 : cval[(g == 0) ? 0 : g - 1]),
      .left_gt   ((g == 0) ? 1'b0 : cgt[(g == 0) ? 0 : g - 1]),
      .right_val (cval[(g == DEPTH - 1) ? g : g + 1]),
      .val_r     (cval[g]),
      .gt_r      (cgt[g]),
      .eq_r      (ceq[g]),
      .sel_r     (csel[g])
    );
  end

  always_comb begin
    count_nxt    = count_r;
    out_word_nxt = '0;
    unique case (cmd_r.action)
      ACT_INSERT: begin
        if (full) begin
          out_word_nxt.status = STS_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_DELETE: begin
        if (match) begin
          count_nxt = count_r - CW'(1);
        end else begin
          out_word_nxt.status = STS_ABSENT;
        end
      end
      ACT_FIND: begin
        if (match) begin
          out_word_nxt.position = match_pos;
        end else begin
          out_word_nxt.status = STS_ABSENT;
        end
      end
      ACT_READ: begin
        if (read_hit) begin
          out_word_nxt.read_value = read_data;
        end else begin
          out_word_nxt.status = STS_ABSENT;
        end
      end
      ACT_CLEAR: count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
    out_word_nxt.entry_count = 5'(32'(count_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.exe;
      if (ctrl.exe) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exe) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_exe_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXE |=> out_valid)
    else $error("result strobe missing after execute");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted word did not raise busy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == STS_FULL |-> count_r == CW'(DEPTH))
    else $error("full status with room left");

endmodule
`default_nettype wire

### design/sle_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted chain: holds a value, compares it against the
// broadcast word and shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctl_t          ctl,
  input  wire logic signed [31:0] cmd_value,
  input  wire logic [3:0]         cmd_index,
  input  wire logic [CW-1:0]      count,
  input  wire logic signed [31:0] left_val,
  input  wire logic               left_gt,
  input  wire logic signed [31:0] right_val,
  output logic signed [31:0]      val_r,
  output logic                    gt_r,
  output logic                    eq_r,
  output logic                    sel_r
);

  logic               valid;
  logic               at_count;
  logic               in_range;
  logic               ge_r;
  logic signed [31:0] val_nxt;

  assign valid    = CW'(IDX) < count;
  assign at_count = CW'(IDX) == count;
  assign in_range = CW'(IDX) <= count;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && in_range) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt_r || at_count) begin
        val_nxt = cmd_value;
      end
    end else if (ctl.del && ge_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r  <= 1'b0;
      eq_r  <= 1'b0;
      ge_r  <= 1'b0;
      sel_r <= 1'b0;
    end else if (ctl.cmp) begin
      gt_r  <= valid && (val_r > cmd_value);
      eq_r  <= valid && (val_r == cmd_value);
      ge_r  <= valid && (val_r >= cmd_value);
      sel_r <= valid && ({28'd0, cmd_index} == 32'(IDX));
    end
  end

endmodule
`default_nettype wire

### design/sle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer: load the command word, compare in every cell, then execute.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output ctrl_t     ctrl,
  output state_e    state_r
);

  state_e state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_EXE;
      ST_EXE:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE: ctrl.load = start;
      ST_CMP: begin
        ctrl.busy = 1'b1;
        ctrl.cmp  = 1'b1;
      end
      ST_EXE: begin
        ctrl.busy = 1'b1;
        ctrl.exe  = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
